>>> design/vift_pkg.sv
// Shared types, codes and helpers for the VLAN ID filter and translate block.
// Used by vift_tables, vift_decide and vlan_id_filter_and_translate.
`default_nettype none

package vift_pkg;

  // Field widths
  localparam int VID_W = 12;
  localparam int IDX_W = 3;
  localparam int CMD_W = 2;
  localparam int ACT_W = 2;

  // Entries that an index field can address per direction
  localparam int IDX_SLOTS = 1 << IDX_W;

  // Default table depths per direction
  localparam int FILTER_DEPTH_DEF = 8;
  localparam int MAP_DEPTH_DEF    = 8;

  // Command codes
  localparam logic [CMD_W-1:0] CMD_FRAME    = 2'd0;
  localparam logic [CMD_W-1:0] CMD_FILT_WR  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_MAP_WR   = 2'd2;

  // Tag action codes
  localparam logic [ACT_W-1:0] ACT_KEEP    = 2'd0;
  localparam logic [ACT_W-1:0] ACT_ADD     = 2'd1;
  localparam logic [ACT_W-1:0] ACT_REMOVE  = 2'd2;
  localparam logic [ACT_W-1:0] ACT_REWRITE = 2'd3;

  // Table write request
  typedef struct packed {
    logic             filt_we;
    logic             map_we;
    logic             dir;
    logic [IDX_W-1:0] idx;
    logic             valid;
    logic             from_tagged;
    logic [VID_W-1:0] from_vid;
    logic             to_tagged;
    logic [VID_W-1:0] to_vid;
  } table_wr_t;

  // Table lookup status for one candidate ID
  typedef struct packed {
    logic             filt_any;
    logic             filt_hit;
    logic             map_hit;
    logic             map_to_tagged;
    logic [VID_W-1:0] map_to_vid;
  } lookup_t;

  // Two untagged IDs match; tagged IDs match by value
  function automatic logic same_id(input logic ta, input logic [VID_W-1:0] va,
                                   input logic tb, input logic [VID_W-1:0] vb);
    return (ta == tb) && (!ta || (va == vb));
  endfunction

endpackage

`default_nettype wire

>>> design/vift_tables.sv
// Filter and translation tables, per direction, with parallel lookup.
// Depends on vift_pkg for the write and lookup structs and same_id.
`default_nettype none

module vift_tables #(
  parameter int FILTER_DEPTH = vift_pkg::FILTER_DEPTH_DEF,
  parameter int MAP_DEPTH    = vift_pkg::MAP_DEPTH_DEF
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire vift_pkg::table_wr_t        wr,
  input  wire logic                       q_dir,
  input  wire logic                       q_tagged,
  input  wire logic [vift_pkg::VID_W-1:0] q_vid,
  output vift_pkg::lookup_t               lk
);

  // Only entries below the index range can ever be written
  localparam int FILT_N = (FILTER_DEPTH < vift_pkg::IDX_SLOTS) ? FILTER_DEPTH
                                                               : vift_pkg::IDX_SLOTS;
  localparam int MAP_N  = (MAP_DEPTH < vift_pkg::IDX_SLOTS) ? MAP_DEPTH
                                                            : vift_pkg::IDX_SLOTS;

  logic                       filt_vld_r [2][FILT_N];
  logic                       filt_tag_r [2][FILT_N];
  logic [vift_pkg::VID_W-1:0] filt_vid_r [2][FILT_N];

  logic                       map_vld_r     [2][MAP_N];
  logic                       map_from_tg_r [2][MAP_N];
  logic [vift_pkg::VID_W-1:0] map_from_vid_r[2][MAP_N];
  logic                       map_to_tg_r   [2][MAP_N];
  logic [vift_pkg::VID_W-1:0] map_to_vid_r  [2][MAP_N];

  // Valid bits: clear at reset, load on a matching write
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int d = 0; d < 2; d++) begin
        for (int i = 0; i < FILT_N; i++) filt_vld_r[d][i] <= 1'b0;
        for (int i = 0; i < MAP_N; i++)  map_vld_r[d][i]  <= 1'b0;
      end
    end else begin
      for (int i = 0; i < FILT_N; i++) begin
        if (wr.filt_we && (wr.idx == vift_pkg::IDX_W'(i))) begin
          filt_vld_r[wr.dir][i] <= wr.valid;
        end
      end
      for (int i = 0; i < MAP_N; i++) begin
        if (wr.map_we && (wr.idx == vift_pkg::IDX_W'(i))) begin
          map_vld_r[wr.dir][i] <= wr.valid;
        end
      end
    end
  end

  // Entry payload: no reset, gated by valid on read
  always_ff @(posedge clk) begin
    for (int i = 0; i < FILT_N; i++) begin
      if (wr.filt_we && (wr.idx == vift_pkg::IDX_W'(i))) begin
        filt_tag_r[wr.dir][i] <= wr.from_tagged;
        filt_vid_r[wr.dir][i] <= wr.from_vid;
      end
    end
    for (int i = 0; i < MAP_N; i++) begin
      if (wr.map_we && (wr.idx == vift_pkg::IDX_W'(i))) begin
        map_from_tg_r[wr.dir][i]  <= wr.from_tagged;
        map_from_vid_r[wr.dir][i] <= wr.from_vid;
        map_to_tg_r[wr.dir][i]    <= wr.to_tagged;
        map_to_vid_r[wr.dir][i]   <= wr.to_vid;
      end
    end
  end

  // Compare candidate against all entries; lowest map index wins
  always_comb begin
    lk = '0;
    for (int i = 0; i < FILT_N; i++) begin
      if (filt_vld_r[q_dir][i]) begin
        lk.filt_any = 1'b1;
        if (vift_pkg::same_id(filt_tag_r[q_dir][i], filt_vid_r[q_dir][i],
                              q_tagged, q_vid)) begin
          lk.filt_hit = 1'b1;
        end
      end
    end
    for (int i = MAP_N - 1; i >= 0; i--) begin
      if (map_vld_r[q_dir][i] &&
          vift_pkg::same_id(map_from_tg_r[q_dir][i], map_from_vid_r[q_dir][i],
                            q_tagged, q_vid)) begin
        lk.map_hit       = 1'b1;
        lk.map_to_tagged = map_to_tg_r[q_dir][i];
        lk.map_to_vid    = map_to_vid_r[q_dir][i];
      end
    end
  end

endmodule

`default_nettype wire

>>> design/vift_decide.sv
// Forward/drop decision, ID translation and tag action for one frame.
// Depends on vift_pkg for the lookup struct, action codes and same_id.
`default_nettype none

module vift_decide (
  input  wire logic                       old_tagged,
  input  wire logic [vift_pkg::VID_W-1:0] old_vid,
  input  wire logic                       cand_tagged,
  input  wire logic [vift_pkg::VID_W-1:0] cand_vid,
  input  wire vift_pkg::lookup_t          lk,
  output logic                            accepted,
  output logic [vift_pkg::ACT_W-1:0]      action,
  output logic                            new_tagged,
  output logic [vift_pkg::VID_W-1:0]      new_vid
);

  logic                       xl_tagged;
  logic [vift_pkg::VID_W-1:0] xl_vid;

  // Empty filter accepts all
  assign accepted = !lk.filt_any || lk.filt_hit;

  // Translate on a map hit, else keep the candidate
  assign xl_tagged = lk.map_hit ? lk.map_to_tagged : cand_tagged;
  assign xl_vid    = lk.map_hit ? lk.map_to_vid    : cand_vid;

  // Resolve the tag action and report untagged IDs as zero
  always_comb begin
    action     = vift_pkg::ACT_KEEP;
    new_tagged = 1'b0;
    new_vid    = '0;
    if (accepted) begin
      new_tagged = xl_tagged;
      new_vid    = xl_tagged ? xl_vid : '0;
      if (!vift_pkg::same_id(xl_tagged, xl_vid, old_tagged, old_vid)) begin
        if (!old_tagged && xl_tagged) begin
          action = vift_pkg::ACT_ADD;
        end else if (old_tagged && !xl_tagged) begin
          action = vift_pkg::ACT_REMOVE;
        end else begin
          action = vift_pkg::ACT_REWRITE;
        end
      end
    end
  end

endmodule

`default_nettype wire

>>> design/vlan_id_filter_and_translate.sv
// Top level of the VLAN ID filter and translate block: input register,
// tables, decision logic and result register. Depends on vift_pkg,
// vift_tables and vift_decide.
//
// Usage:
//   Items enter on start with the in_* fields; busy stays low, so an item is
//   transferred in every cycle that start is high. in_cmd selects a frame
//   decision, a filter entry write or a translation entry write; code 3 is
//   ignored. Each frame yields one result on the out_* ports for exactly one
//   cycle, marked by out_valid; writes and ignored items yield none.
//   A frame's result passes through the input register, then the result
//   register, before it shows on the out_* ports. Throughput: one item per
//   cycle, set by a combinational parallel compare over the eight-or-fewer
//   entries of each table. A table write takes effect for any item
//   transferred in a later cycle.
//   The tag_select register is written through cfg_valid/cfg_data; cfg_ready
//   is always high. Write it only while no frame is in flight.
//   Reset clears all table valid bits, tag_select and the pipeline valids.
//   The receiver cannot stall; results are never held back.
`default_nettype none

module vlan_id_filter_and_translate #(
  parameter int FILTER_DEPTH = vift_pkg::FILTER_DEPTH_DEF,
  parameter int MAP_DEPTH    = vift_pkg::MAP_DEPTH_DEF
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  // Input channel
  input  wire logic                       start,
  output logic                            busy,
  input  wire logic [vift_pkg::CMD_W-1:0] in_cmd,
  input  wire logic                       in_direction,
  input  wire logic [vift_pkg::IDX_W-1:0] in_index,
  input  wire logic                       in_old_tagged,
  input  wire logic [vift_pkg::VID_W-1:0] in_old_vid,
  input  wire logic                       in_req_present,
  input  wire logic [vift_pkg::VID_W-1:0] in_req_vid,
  input  wire logic                       in_entry_valid,
  input  wire logic                       in_entry_from_tagged,
  input  wire logic [vift_pkg::VID_W-1:0] in_entry_from_vid,
  input  wire logic                       in_entry_to_tagged,
  input  wire logic [vift_pkg::VID_W-1:0] in_entry_to_vid,
  // Result channel
  output logic                            out_valid,
  output logic                            out_accepted,
  output logic [vift_pkg::ACT_W-1:0]      out_tag_action,
  output logic                            out_tagged,
  output logic [vift_pkg::VID_W-1:0]      out_vid,
  output logic                            out_tag_kind,
  output logic                            out_direction,
  // Configuration channel
  input  wire logic                       cfg_valid,
  output logic                            cfg_ready,
  input  wire logic                       cfg_data
);

  logic                       s1_valid_r;
  logic [vift_pkg::CMD_W-1:0] s1_cmd_r;
  logic                       s1_dir_r;
  logic [vift_pkg::IDX_W-1:0] s1_idx_r;
  logic                       s1_old_tagged_r;
  logic [vift_pkg::VID_W-1:0] s1_old_vid_r;
  logic                       s1_req_present_r;
  logic [vift_pkg::VID_W-1:0] s1_req_vid_r;
  logic                       s1_e_valid_r;
  logic                       s1_e_from_tg_r;
  logic [vift_pkg::VID_W-1:0] s1_e_from_vid_r;
  logic                       s1_e_to_tg_r;
  logic [vift_pkg::VID_W-1:0] s1_e_to_vid_r;

  logic                       tag_sel_r;
  logic                       in_xfer;
  logic                       s1_frame;

  vift_pkg::table_wr_t        tbl_wr;
  vift_pkg::lookup_t          tbl_lk;
  logic                       cand_tagged;
  logic [vift_pkg::VID_W-1:0] cand_vid;

  logic                       dec_accepted;
  logic [vift_pkg::ACT_W-1:0] dec_action;
  logic                       dec_tagged;
  logic [vift_pkg::VID_W-1:0] dec_vid;

  logic                       out_valid_r;
  logic                       out_accepted_r;
  logic [vift_pkg::ACT_W-1:0] out_action_r;
  logic                       out_tagged_r;
  logic [vift_pkg::VID_W-1:0] out_vid_r;
  logic                       out_kind_r;
  logic                       out_dir_r;

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;
  assign in_xfer   = start && !busy;

  // Hold tag select until the next configuration transfer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tag_sel_r <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      tag_sel_r <= cfg_data;
    end
  end

  // Capture each transferred item in the input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= in_xfer;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_cmd_r         <= in_cmd;
      s1_dir_r         <= in_direction;
      s1_idx_r         <= in_index;
      s1_old_tagged_r  <= in_old_tagged;
      s1_old_vid_r     <= in_old_vid;
      s1_req_present_r <= in_req_present;
      s1_req_vid_r     <= in_req_vid;
      s1_e_valid_r     <= in_entry_valid;
      s1_e_from_tg_r   <= in_entry_from_tagged;
      s1_e_from_vid_r  <= in_entry_from_vid;
      s1_e_to_tg_r     <= in_entry_to_tagged;
      s1_e_to_vid_r    <= in_entry_to_vid;
    end
  end

  // Decode table writes from the input register
  always_comb begin
    tbl_wr             = '0;
    tbl_wr.filt_we     = s1_valid_r && (s1_cmd_r == vift_pkg::CMD_FILT_WR);
    tbl_wr.map_we      = s1_valid_r && (s1_cmd_r == vift_pkg::CMD_MAP_WR);
    tbl_wr.dir         = s1_dir_r;
    tbl_wr.idx         = s1_idx_r;
    tbl_wr.valid       = s1_e_valid_r;
    tbl_wr.from_tagged = s1_e_from_tg_r;
    tbl_wr.from_vid    = s1_e_from_vid_r;
    tbl_wr.to_tagged   = s1_e_to_tg_r;
    tbl_wr.to_vid      = s1_e_to_vid_r;
  end

  assign s1_frame = s1_valid_r && (s1_cmd_r == vift_pkg::CMD_FRAME);

  // Requested ID overrides the frame's own
  assign cand_tagged = s1_req_present_r ? 1'b1 : s1_old_tagged_r;
  assign cand_vid    = s1_req_present_r ? s1_req_vid_r : s1_old_vid_r;

  vift_tables #(
    .FILTER_DEPTH (FILTER_DEPTH),
    .MAP_DEPTH    (MAP_DEPTH)
  ) u_tables (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr       (tbl_wr),
    .q_dir    (s1_dir_r),
    .q_tagged (cand_tagged),
    .q_vid    (cand_vid),
    .lk       (tbl_lk)
  );

  vift_decide u_decide (
    .old_tagged  (s1_old_tagged_r),
    .old_vid     (s1_old_vid_r),
    .cand_tagged (cand_tagged),
    .cand_vid    (cand_vid),
    .lk          (tbl_lk),
    .accepted    (dec_accepted),
    .action      (dec_action),
    .new_tagged  (dec_tagged),
    .new_vid     (dec_vid)
  );

  // Register the result of each frame for one strobe cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= s1_frame;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_frame) begin
      out_accepted_r <= dec_accepted;
      out_action_r   <= dec_action;
      out_tagged_r   <= dec_tagged;
      out_vid_r      <= dec_vid;
      out_kind_r     <= tag_sel_r;
      out_dir_r      <= s1_dir_r;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_accepted   = out_accepted_r;
  assign out_tag_action = out_action_r;
  assign out_tagged     = out_tagged_r;
  assign out_vid        = out_vid_r;
  assign out_tag_kind   = out_kind_r;
  assign out_direction  = out_dir_r;

  // A result comes only from a frame held in the input register last cycle
  a_result_from_frame: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(s1_valid_r && (s1_cmd_r == vift_pkg::CMD_FRAME)))
    else $error("result strobe without a frame in the input register");

  // A frame in the input register always gives a result next cycle
  a_frame_to_result: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && (s1_cmd_r == vift_pkg::CMD_FRAME)) |=> out_valid)
    else $error("frame lost between input and result registers");

  // Dropped frames carry no tag and keep action
  a_drop_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_accepted) |->
      (out_tag_action == vift_pkg::ACT_KEEP) && !out_tagged && (out_vid == '0))
    else $error("dropped frame reports a tag or action");

  // Untagged results report ID zero and never add or rewrite
  a_untagged_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_tagged) |->
      (out_vid == '0) && (out_tag_action != vift_pkg::ACT_ADD) &&
      (out_tag_action != vift_pkg::ACT_REWRITE))
    else $error("untagged result with nonzero ID or tagging action");

endmodule

`default_nettype wire
